/* hdl/pdir_pkg.sv */
package pdir_pkg;

    localparam int W_BITS        = 24;
    localparam int BITS_PER_BYTE = 8;

    typedef enum logic [1:0] {
        KIND_PULSE   = 2'd0,
        KIND_SPACE   = 2'd1,
        KIND_TIMEOUT = 2'd2,
        KIND_FREQ    = 2'd3
    } t_mark_kind;

    typedef enum logic [1:0] {
        EV_BYTE        = 2'd0,
        EV_START       = 2'd1,
        EV_END         = 2'd2,
        EV_UNSUPPORTED = 2'd3
    } t_event;

    typedef enum logic [2:0] {
        CFG_START_PULSE = 3'd0,
        CFG_START_SPACE = 3'd1,
        CFG_ONE_PULSE   = 3'd2,
        CFG_ONE_SPACE   = 3'd3,
        CFG_ZERO_PULSE  = 3'd4,
        CFG_ZERO_SPACE  = 3'd5,
        CFG_TOLERANCE   = 3'd6
    } t_cfg_idx;

    typedef struct packed {
        logic [W_BITS-1:0] start_pulse;
        logic [W_BITS-1:0] start_space;
        logic [W_BITS-1:0] one_pulse;
        logic [W_BITS-1:0] one_space;
        logic [W_BITS-1:0] zero_pulse;
        logic [W_BITS-1:0] zero_space;
        logic [W_BITS-1:0] tolerance;
    } t_cfg;

    // nominal - tol <= w <= nominal + tol, one bit wider so nothing wraps
    function automatic logic in_window(
        input logic [W_BITS-1:0] w,
        input logic [W_BITS-1:0] nominal,
        input logic [W_BITS-1:0] tol
    );
        logic [W_BITS:0] w_plus;
        logic [W_BITS:0] hi;
        w_plus = {1'b0, w} + {1'b0, tol};
        hi     = {1'b0, nominal} + {1'b0, tol};
        return (w_plus >= {1'b0, nominal}) && ({1'b0, w} <= hi);
    endfunction

endpackage

/* hdl/pulse_distance_ir_decoder_top.sv */
// Pulse-distance infrared receive decoder. Each mark request (tuser = kind, tdata = width in
// microseconds) is paired with the previous pulse/space/timeout mark and judged against the
// start, one and zero windows (nominal plus or minus tolerance) held in the seven
// configuration registers. A request passes through an input register and a result
// register, and one request is taken every cycle, limited only by the result register
// waiting on i_m_axis_tready when a request produces an event. Events are
// byte complete (with the byte, LSB received first), frame start, end of reception and
// unsupported frequency mark; other requests produce nothing. Configure only while idle.
module pulse_distance_ir_decoder_top (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_wr_en,
    input  logic [2:0]                  i_cfg_addr,
    input  logic [pdir_pkg::W_BITS-1:0] i_cfg_wdata,
    input  logic                        i_s_axis_tvalid,
    output logic                        o_s_axis_tready,
    input  logic [23:0]                 i_s_axis_tdata,  // width_us
    input  logic [1:0]                  i_s_axis_tuser,  // mark_kind
    output logic                        o_m_axis_tvalid,
    input  logic                        i_m_axis_tready,
    output logic [7:0]                  o_m_axis_tdata,  // data_byte
    output logic [1:0]                  o_m_axis_tuser   // event_res
);

    pdir_pkg::t_cfg                r_cfg;
    logic                          r_in_valid;
    pdir_pkg::t_mark_kind          r_in_kind;
    logic [pdir_pkg::W_BITS-1:0]   r_in_width;
    logic                          r_prev_valid;
    pdir_pkg::t_mark_kind          r_prev_kind;
    logic [pdir_pkg::W_BITS-1:0]   r_prev_width;
    logic [7:0]                    r_shift;
    logic [3:0]                    r_bit_count;
    logic                          r_frame_open;
    logic                          r_out_valid;
    pdir_pkg::t_event              r_out_event;
    logic [7:0]                    r_out_byte;

    logic                          n_prev_valid;
    pdir_pkg::t_mark_kind          n_prev_kind;
    logic [pdir_pkg::W_BITS-1:0]   n_prev_width;
    logic [7:0]                    n_shift;
    logic [3:0]                    n_bit_count;
    logic                          n_frame_open;
    logic                          n_has_result;
    pdir_pkg::t_event              n_event;
    logic [7:0]                    n_byte;

    logic                          pulse_space;
    logic                          start_hit;
    logic                          zero_hit;
    logic                          one_hit;
    logic                          advance;
    logic                          out_free;

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_wr_en) begin
            unique case (pdir_pkg::t_cfg_idx'(i_cfg_addr))
                pdir_pkg::CFG_START_PULSE: r_cfg.start_pulse <= i_cfg_wdata;
                pdir_pkg::CFG_START_SPACE: r_cfg.start_space <= i_cfg_wdata;
                pdir_pkg::CFG_ONE_PULSE:   r_cfg.one_pulse   <= i_cfg_wdata;
                pdir_pkg::CFG_ONE_SPACE:   r_cfg.one_space   <= i_cfg_wdata;
                pdir_pkg::CFG_ZERO_PULSE:  r_cfg.zero_pulse  <= i_cfg_wdata;
                pdir_pkg::CFG_ZERO_SPACE:  r_cfg.zero_space  <= i_cfg_wdata;
                pdir_pkg::CFG_TOLERANCE:   r_cfg.tolerance   <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // pattern matching against previous mark
    always_comb begin
        pulse_space = (r_prev_kind == pdir_pkg::KIND_PULSE) &&
                      (r_in_kind == pdir_pkg::KIND_SPACE);
        start_hit = pulse_space &&
            pdir_pkg::in_window(r_prev_width, r_cfg.start_pulse, r_cfg.tolerance) &&
            pdir_pkg::in_window(r_in_width, r_cfg.start_space, r_cfg.tolerance);
        zero_hit = pulse_space &&
            pdir_pkg::in_window(r_prev_width, r_cfg.zero_pulse, r_cfg.tolerance) &&
            pdir_pkg::in_window(r_in_width, r_cfg.zero_space, r_cfg.tolerance);
        one_hit = pulse_space &&
            pdir_pkg::in_window(r_prev_width, r_cfg.one_pulse, r_cfg.tolerance) &&
            pdir_pkg::in_window(r_in_width, r_cfg.one_space, r_cfg.tolerance);
    end

    // decode and next state
    always_comb begin
        n_prev_valid = r_prev_valid;
        n_prev_kind  = r_prev_kind;
        n_prev_width = r_prev_width;
        n_shift      = r_shift;
        n_bit_count  = r_bit_count;
        n_frame_open = r_frame_open;
        n_has_result = 1'b0;
        n_event      = pdir_pkg::EV_BYTE;
        n_byte       = 8'd0;
        if (r_in_kind == pdir_pkg::KIND_FREQ) begin
            n_has_result = 1'b1;
            n_event      = pdir_pkg::EV_UNSUPPORTED;
        end else begin
            n_prev_valid = 1'b1;
            n_prev_kind  = r_in_kind;
            n_prev_width = r_in_width;
            if (r_prev_valid) begin
                priority if ((r_prev_kind == pdir_pkg::KIND_PULSE) &&
                             (r_in_kind == pdir_pkg::KIND_TIMEOUT)) begin
                    n_shift      = 8'd0;
                    n_bit_count  = 4'd0;
                    n_has_result = 1'b1;
                    n_event      = pdir_pkg::EV_END;
                end else if (start_hit) begin
                    n_frame_open = 1'b1;
                    n_shift      = 8'd0;
                    n_bit_count  = 4'd0;
                    n_has_result = 1'b1;
                    n_event      = pdir_pkg::EV_START;
                end else if (r_frame_open) begin
                    if (zero_hit) begin
                        n_bit_count = r_bit_count + 4'd1;
                    end else if (one_hit) begin
                        n_shift     = r_shift | (8'd1 << r_bit_count[2:0]);
                        n_bit_count = r_bit_count + 4'd1;
                    end
                    if (n_bit_count == 4'(pdir_pkg::BITS_PER_BYTE)) begin
                        n_has_result = 1'b1;
                        n_event      = pdir_pkg::EV_BYTE;
                        n_byte       = n_shift;
                        n_shift      = 8'd0;
                        n_bit_count  = 4'd0;
                    end
                end else begin
                end
            end
        end
    end

    assign out_free        = !r_out_valid || i_m_axis_tready;
    assign advance         = r_in_valid && (out_free || !n_has_result);
    assign o_s_axis_tready = !r_in_valid || advance;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_in_kind  <= pdir_pkg::t_mark_kind'(i_s_axis_tuser);
            r_in_width <= i_s_axis_tdata;
        end
    end

    // decoder state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_valid <= 1'b0;
            r_prev_kind  <= pdir_pkg::KIND_PULSE;
            r_prev_width <= '0;
            r_shift      <= 8'd0;
            r_bit_count  <= 4'd0;
            r_frame_open <= 1'b0;
        end else if (advance) begin
            r_prev_valid <= n_prev_valid;
            r_prev_kind  <= n_prev_kind;
            r_prev_width <= n_prev_width;
            r_shift      <= n_shift;
            r_bit_count  <= n_bit_count;
            r_frame_open <= n_frame_open;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= advance && n_has_result;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free && advance && n_has_result) begin
            r_out_event <= n_event;
            r_out_byte  <= n_byte;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_byte;
    assign o_m_axis_tuser  = r_out_event;

    a_bit_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bit_count < 4'(pdir_pkg::BITS_PER_BYTE))
        else $error("pending bit count reached a full byte");

    a_data_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out_event != pdir_pkg::EV_BYTE)) |-> (r_out_byte == 8'd0))
        else $error("non-byte event carries data");

    a_freq_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && (r_in_kind == pdir_pkg::KIND_FREQ)) |=>
        (r_out_valid && (r_out_event == pdir_pkg::EV_UNSUPPORTED)))
        else $error("frequency mark did not report unsupported");

    a_frame_stays_open: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$fell(r_frame_open))
        else $error("frame closed without reset");

endmodule

/* test/pulse_distance_ir_decoder_top_tb.sv */
`timescale 1ns / 1ps

module pulse_distance_ir_decoder_top_tb;

    localparam int                W_BITS        = pdir_pkg::W_BITS;
    localparam int                BITS_PER_BYTE = pdir_pkg::BITS_PER_BYTE;
    localparam int                CLK_PERIOD    = 8;
    localparam int                SETTLE        = 4;
    localparam int                HOLD_CYCLES   = 300;
    localparam int                LIMIT_CYCLES  = 500000;
    localparam logic [W_BITS-1:0] W_MAX         = {W_BITS{1'b1}};
    localparam logic [2:0]        CFG_NONE      = 3'd7;

    typedef struct {
        pdir_pkg::t_mark_kind kind;
        logic [W_BITS-1:0]    width;
    } t_ir_mark;

    typedef struct {
        pdir_pkg::t_event ev;
        logic [7:0]       data;
    } t_ir_event;

    logic              i_clk;
    logic              i_rst_n         = 1'b0;
    logic              i_cfg_wr_en     = 1'b0;
    logic [2:0]        i_cfg_addr      = '0;
    logic [W_BITS-1:0] i_cfg_wdata     = '0;
    logic              i_s_axis_tvalid = 1'b0;
    logic              o_s_axis_tready;
    logic [23:0]       i_s_axis_tdata  = '0;  // width_us
    logic [1:0]        i_s_axis_tuser  = '0;  // mark_kind
    logic              o_m_axis_tvalid;
    logic              i_m_axis_tready = 1'b0;
    logic [7:0]        o_m_axis_tdata;        // data_byte
    logic [1:0]        o_m_axis_tuser;        // event_res

    pulse_distance_ir_decoder_top u_dut (.*);

    // decoder state as predicted
    pdir_pkg::t_cfg       timing     = '0;
    logic                 have_prev  = 1'b0;
    pdir_pkg::t_mark_kind prev_kind  = pdir_pkg::KIND_PULSE;
    logic [W_BITS-1:0]    prev_width = '0;
    logic [7:0]           shift_byte = '0;
    logic [3:0]           bit_count  = '0;
    logic                 frame_open = 1'b0;

    t_ir_mark  marks_to_send[$];
    t_ir_event due_events[$];

    int   marks_queued = 0;
    int   marks_taken  = 0;
    int   send_gap     = 0;
    int   stall_left   = 0;
    int   hold_left    = 0;
    int   fail_count   = 0;
    int   cycle_count  = 0;
    int   events_seen[4] = '{0, 0, 0, 0};
    bit   idle_on      = 1'b1;
    bit   hold_arm     = 1'b0;
    bit   hold_taken   = 1'b0;

    function automatic void add_due(pdir_pkg::t_event ev, logic [7:0] data);
        due_events.insert(due_events.size(), '{ev, data});
    endfunction

    function automatic bit fits(logic [W_BITS-1:0] w, logic [W_BITS-1:0] nom);
        int lo;
        int hi;
        lo = int'(nom) - int'(timing.tolerance);
        hi = int'(nom) + int'(timing.tolerance);
        return int'(w) >= lo && int'(w) <= hi;
    endfunction

    function automatic bit pair_fits(pdir_pkg::t_mark_kind kind, logic [W_BITS-1:0] w,
                                     logic [W_BITS-1:0] np, logic [W_BITS-1:0] ns);
        return prev_kind == pdir_pkg::KIND_PULSE && kind == pdir_pkg::KIND_SPACE &&
               fits(prev_width, np) && fits(w, ns);
    endfunction

    function automatic void decode_mark(pdir_pkg::t_mark_kind kind, logic [W_BITS-1:0] w);
        if (kind == pdir_pkg::KIND_FREQ) begin
            add_due(pdir_pkg::EV_UNSUPPORTED, 8'd0);
            return;
        end
        if (have_prev) begin
            if (prev_kind == pdir_pkg::KIND_PULSE && kind == pdir_pkg::KIND_TIMEOUT) begin
                shift_byte = '0;
                bit_count  = '0;
                add_due(pdir_pkg::EV_END, 8'd0);
            end else if (pair_fits(kind, w, timing.start_pulse, timing.start_space)) begin
                frame_open = 1'b1;
                shift_byte = '0;
                bit_count  = '0;
                add_due(pdir_pkg::EV_START, 8'd0);
            end else if (frame_open) begin
                // zero pattern checked first so it wins where windows overlap
                if (pair_fits(kind, w, timing.zero_pulse, timing.zero_space)) begin
                    bit_count++;
                end else if (pair_fits(kind, w, timing.one_pulse, timing.one_space)) begin
                    shift_byte[bit_count[2:0]] = 1'b1;
                    bit_count++;
                end
                if (bit_count == BITS_PER_BYTE) begin
                    add_due(pdir_pkg::EV_BYTE, shift_byte);
                    shift_byte = '0;
                    bit_count  = '0;
                end
            end
        end
        have_prev  = 1'b1;
        prev_kind  = kind;
        prev_width = w;
    endfunction

    // width inside the window, now and then on an edge or just outside it
    function automatic logic [W_BITS-1:0] near(logic [W_BITS-1:0] nom);
        int lo;
        int hi;
        lo = int'(nom) - int'(timing.tolerance);
        hi = int'(nom) + int'(timing.tolerance);
        if (lo < 0) lo = 0;
        if (hi > int'(W_MAX)) hi = int'(W_MAX);
        case ($urandom_range(0, 31))
            0:       return W_BITS'(lo);
            1:       return W_BITS'(hi);
            2:       return (lo > 0) ? W_BITS'(lo - 1) : W_BITS'(hi);
            3:       return (hi < int'(W_MAX)) ? W_BITS'(hi + 1) : W_BITS'(lo);
            default: return W_BITS'($urandom_range(hi, lo));
        endcase
    endfunction

    function automatic void push_mark(pdir_pkg::t_mark_kind kind, logic [W_BITS-1:0] w);
        marks_to_send.insert(marks_to_send.size(), '{kind, w});
        marks_queued++;
    endfunction

    function automatic void push_pair(logic [W_BITS-1:0] np, logic [W_BITS-1:0] ns);
        push_mark(pdir_pkg::KIND_PULSE, near(np));
        push_mark(pdir_pkg::KIND_SPACE, near(ns));
    endfunction

    function automatic void push_noise();
        push_mark(pdir_pkg::t_mark_kind'($urandom_range(0, 3)), W_BITS'($urandom));
    endfunction

    function automatic void push_frame(int n_bytes);
        bit b;
        push_pair(timing.start_pulse, timing.start_space);
        repeat (n_bytes * BITS_PER_BYTE) begin
            b = 1'($urandom_range(0, 1));
            case ($urandom_range(0, 59))
                0: push_noise();
                1: push_pair(timing.start_pulse, timing.start_space);
                2: begin
                    // end of reception leaves the frame open
                    push_mark(pdir_pkg::KIND_PULSE, near(timing.zero_pulse));
                    push_mark(pdir_pkg::KIND_TIMEOUT, W_BITS'($urandom));
                end
                default: ;
            endcase
            push_mark(pdir_pkg::KIND_PULSE, near(b ? timing.one_pulse : timing.zero_pulse));
            if ($urandom_range(0, 29) == 0) push_mark(pdir_pkg::KIND_FREQ, W_BITS'($urandom));
            push_mark(pdir_pkg::KIND_SPACE, near(b ? timing.one_space : timing.zero_space));
        end
        if ($urandom_range(0, 1) == 1) begin
            push_mark(pdir_pkg::KIND_PULSE, near(timing.one_pulse));
            push_mark(pdir_pkg::KIND_TIMEOUT, W_BITS'($urandom));
        end
    endfunction

    function automatic void run_mix(int n_marks);
        int stop;
        stop = marks_queued + n_marks;
        while (marks_queued < stop) begin
            case ($urandom_range(0, 9))
                0, 1: push_noise();
                2:    push_mark(pdir_pkg::KIND_FREQ, W_BITS'($urandom));
                3: begin
                    push_mark(pdir_pkg::KIND_PULSE, near(timing.start_pulse));
                    push_mark(pdir_pkg::KIND_TIMEOUT, W_BITS'($urandom));
                end
                default: push_frame(int'($urandom_range(1, 3)));
            endcase
        end
    endfunction

    task automatic wait_idle();
        @(posedge i_clk);
        while (marks_taken != marks_queued || due_events.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [W_BITS-1:0] val);
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_addr  <= idx;
        i_cfg_wdata <= val;
        case (idx)
            pdir_pkg::CFG_START_PULSE: timing.start_pulse = val;
            pdir_pkg::CFG_START_SPACE: timing.start_space = val;
            pdir_pkg::CFG_ONE_PULSE:   timing.one_pulse   = val;
            pdir_pkg::CFG_ONE_SPACE:   timing.one_space   = val;
            pdir_pkg::CFG_ZERO_PULSE:  timing.zero_pulse  = val;
            pdir_pkg::CFG_ZERO_SPACE:  timing.zero_space  = val;
            pdir_pkg::CFG_TOLERANCE:   timing.tolerance   = val;
            default: ;
        endcase
    endtask

    task automatic load_timings(logic [W_BITS-1:0] sp, logic [W_BITS-1:0] ss,
                                logic [W_BITS-1:0] op, logic [W_BITS-1:0] os,
                                logic [W_BITS-1:0] zp, logic [W_BITS-1:0] zs,
                                logic [W_BITS-1:0] tol);
        write_reg(pdir_pkg::CFG_START_PULSE, sp);
        write_reg(pdir_pkg::CFG_START_SPACE, ss);
        write_reg(pdir_pkg::CFG_ONE_PULSE, op);
        write_reg(pdir_pkg::CFG_ONE_SPACE, os);
        write_reg(pdir_pkg::CFG_ZERO_PULSE, zp);
        write_reg(pdir_pkg::CFG_ZERO_SPACE, zs);
        write_reg(pdir_pkg::CFG_TOLERANCE, tol);
        // unused index, must be ignored
        write_reg(CFG_NONE, W_BITS'($urandom));
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
    endtask

    initial begin
        i_clk = 1'b0;
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin : watchdog
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT_CYCLES) begin
            $display("timed out with %0d marks sent of %0d", marks_taken, marks_queued);
            $display("FAIL pulse_distance_ir_decoder_top");
            $finish;
        end
    end

    always @(posedge i_clk) begin : drive_marks
        t_ir_mark m;
        if (!i_rst_n) begin
            i_s_axis_tvalid <= 1'b0;
        end else begin
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                decode_mark(pdir_pkg::t_mark_kind'(i_s_axis_tuser), i_s_axis_tdata);
                marks_taken++;
            end
            if (!i_s_axis_tvalid || o_s_axis_tready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    i_s_axis_tvalid <= 1'b0;
                end else if (marks_to_send.size() > 0) begin
                    m = marks_to_send.pop_front();
                    i_s_axis_tvalid <= 1'b1;
                    i_s_axis_tdata  <= m.width;
                    i_s_axis_tuser  <= m.kind;
                    if (idle_on && $urandom_range(0, 7) == 0) send_gap = $urandom_range(1, 16);
                end else begin
                    i_s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin : drive_ready
        if (!i_rst_n) begin
            i_m_axis_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            i_m_axis_tready <= 1'b0;
        end else if (hold_arm && !hold_taken) begin
            hold_taken = 1'b1;
            hold_left  = HOLD_CYCLES;
            i_m_axis_tready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            i_m_axis_tready <= 1'b0;
        end else begin
            i_m_axis_tready <= 1'b1;
            if (idle_on && $urandom_range(0, 7) == 0) stall_left = $urandom_range(1, 16);
        end
    end

    always @(posedge i_clk) begin : check_events
        t_ir_event want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (due_events.size() == 0) begin
                $error("event with none due: event_res %0d data_byte 0x%02h",
                       o_m_axis_tuser, o_m_axis_tdata);
                fail_count++;
            end else begin
                want = due_events.pop_front();
                if (o_m_axis_tuser !== want.ev) begin
                    $error("event_res expected %0d got %0d", want.ev, o_m_axis_tuser);
                    fail_count++;
                end
                if (o_m_axis_tdata !== want.data) begin
                    $error("data_byte expected 0x%02h got 0x%02h", want.data, o_m_axis_tdata);
                    fail_count++;
                end
                events_seen[int'(want.ev)]++;
            end
        end
    end

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // typical header and bit timings
        load_timings(24'd9000, 24'd4500, 24'd560, 24'd1690, 24'd560, 24'd560, 24'd200);
        push_mark(pdir_pkg::KIND_PULSE, timing.zero_pulse);
        push_mark(pdir_pkg::KIND_SPACE, timing.zero_space);
        push_mark(pdir_pkg::KIND_PULSE, '0);
        push_mark(pdir_pkg::KIND_TIMEOUT, W_MAX);
        push_mark(pdir_pkg::KIND_PULSE, timing.start_pulse - timing.tolerance);
        push_mark(pdir_pkg::KIND_SPACE, timing.start_space + timing.tolerance);
        // frequency mark between the halves of a one bit
        push_mark(pdir_pkg::KIND_PULSE, timing.one_pulse + timing.tolerance);
        push_mark(pdir_pkg::KIND_FREQ, W_MAX);
        push_mark(pdir_pkg::KIND_SPACE, timing.one_space + timing.tolerance);
        push_mark(pdir_pkg::KIND_PULSE, timing.zero_pulse + timing.tolerance + 1);
        push_mark(pdir_pkg::KIND_SPACE, timing.zero_space - timing.tolerance - 1);
        push_mark(pdir_pkg::KIND_TIMEOUT, '0);
        repeat (6) begin
            push_mark(pdir_pkg::KIND_PULSE, timing.one_pulse);
            push_mark(pdir_pkg::KIND_SPACE, timing.one_space);
        end
        push_mark(pdir_pkg::KIND_PULSE, timing.one_pulse - timing.tolerance);
        push_mark(pdir_pkg::KIND_SPACE, timing.one_space - timing.tolerance);
        wait_idle();
        run_mix(450);
        wait_idle();

        // extremes, exact match only
        load_timings(W_MAX, W_MAX, '0, W_MAX, W_MAX, '0, '0);
        run_mix(250);
        wait_idle();

        // widest tolerance: every pulse and space pair is a header
        idle_on = 1'b0;
        load_timings('0, '0, W_MAX, W_MAX, W_MAX, W_MAX, W_MAX);
        run_mix(100);
        wait_idle();

        // overlapping one and zero windows, with a long receiver hold
        idle_on = 1'b1;
        load_timings(24'd4000, 24'd2000, 24'd500, 24'd600, 24'd520, 24'd560, 24'd100);
        hold_arm = 1'b1;
        run_mix(150);
        wait_idle();
        run_mix(150);
        wait_idle();

        // random timings, no idling
        idle_on = 1'b0;
        load_timings(W_BITS'($urandom_range(2000, 20000)), W_BITS'($urandom_range(1000, 10000)),
                     W_BITS'($urandom_range(100, 2000)), W_BITS'($urandom_range(100, 3000)),
                     W_BITS'($urandom_range(100, 2000)), W_BITS'($urandom_range(100, 3000)),
                     W_BITS'($urandom_range(0, 400)));
        run_mix(330);
        wait_idle();

        $display("%0d marks over five timing sets incl. extremes, %0d events checked",
                 marks_taken, events_seen.sum());
        $display("bytes %0d, frame starts %0d, ends %0d, unsupported marks %0d",
                 events_seen[pdir_pkg::EV_BYTE], events_seen[pdir_pkg::EV_START],
                 events_seen[pdir_pkg::EV_END], events_seen[pdir_pkg::EV_UNSUPPORTED]);
        if (fail_count == 0) begin
            $display("PASS pulse_distance_ir_decoder_top");
        end else begin
            $display("FAIL pulse_distance_ir_decoder_top");
        end
        $finish;
    end

endmodule
